// File: design/fgpb_pkg.sv
// Shared constants, register codes and item types of the film grain pixel blend.
// No dependencies; every design file but fgpb_if imports this package.
package fgpb_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 18;

  localparam logic [31:0] HASH_MUL_X = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
  localparam logic [31:0] HASH_MUL_S = 32'd1274126177;

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;

  localparam logic [13:0] LUMA_W_R = 14'd13933;
  localparam logic [15:0] LUMA_W_G = 16'd46871;
  localparam logic [12:0] LUMA_W_B = 13'd4732;

  localparam logic [14:0] MIX_W_HASH  = 15'd19661;
  localparam logic [15:0] MIX_W_GRAIN = 16'd45875;

  localparam logic [17:0] RST_INV_GRAIN_SIZE   = 18'd21845;
  localparam logic [16:0] RST_SHAPING_EXPONENT = 17'd26214;
  localparam logic [15:0] RST_GRAIN_SEED       = 16'd1234;
  localparam logic        RST_COLOR_MODE       = 1'b0;
  localparam logic [16:0] RST_GRAIN_INTENSITY  = 17'd19661;
  localparam logic [16:0] RST_MIX_AMOUNT       = 17'd65536;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_INV_GRAIN_SIZE   = 3'd0,
    CFG_SHAPING_EXPONENT = 3'd1,
    CFG_GRAIN_SEED       = 3'd2,
    CFG_COLOR_MODE       = 3'd3,
    CFG_GRAIN_INTENSITY  = 3'd4,
    CFG_MIX_AMOUNT       = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [17:0] inv_grain_size;
    logic [16:0] shaping_exponent;
    logic [15:0] grain_seed;
    logic        color_mode;
    logic [16:0] grain_intensity;
    logic [16:0] mix_amount;
  } cfg_t;

  typedef struct packed {
    logic [15:0] alpha;
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } pix_t;

  typedef logic [2:0][15:0] hash3_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] noise;
    hash3_t      hc;
    pix_t        pix;
  } noise_item_t;

  typedef struct packed {
    logic        valid;
    logic [16:0] grain;
    hash3_t      hc;
    pix_t        pix;
  } grain_item_t;

endpackage

// File: design/fgpb_if.sv
// Valid/ready channel interfaces for pixel items in and grained pixel items out.
// No dependencies.
interface fgpb_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [15:0] red_in;
  logic [15:0] green_in;
  logic [15:0] blue_in;
  logic [15:0] alpha_in;
  modport source (output valid, pixel_x, pixel_y, red_in, green_in, blue_in, alpha_in,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, red_in, green_in, blue_in, alpha_in,
                  output ready);
endinterface

interface fgpb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;
  logic [15:0] alpha_out;
  modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

// File: design/fgpb_noise.sv
// Six-stage value noise: lattice scaling, corner and pixel hashes, quintic fade,
// bilinear blend. Depends on fgpb_pkg.
module fgpb_noise #(
  parameter int MAX_WIDTH  = fgpb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fgpb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [11:0]           pixel_x,
  input  logic [11:0]           pixel_y,
  input  fgpb_pkg::pix_t        pix_in,
  input  fgpb_pkg::cfg_t        cfg,
  output fgpb_pkg::noise_item_t item_out
);
  import fgpb_pkg::*;

  function automatic logic [15:0] lerp_q16(logic [15:0] a, logic [15:0] b, logic [16:0] s);
    logic [33:0] acc;
    acc = {1'b0, (ONE_Q16 - s)} * {18'd0, a} + {1'b0, s} * {18'd0, b};
    return acc[31:16];
  endfunction

  logic [5:0]        vld_r;
  pix_t [5:0]        pix_r;
  logic [11:0]       x_clamp, y_clamp;
  logic [1:0][29:0]  pos_nxt, pos_r;
  logic [1:0][11:0]  pxy_r;
  logic [1:0][31:0]  ax_nxt, ax_r, ay_nxt, ay_r;
  logic [2:0][31:0]  as_nxt, as_r;
  logic [31:0]       cx_nxt, cx_r, cy_nxt, cy_r;
  logic [1:0][31:0]  tsq;
  logic [1:0][36:0]  poly;
  logic [1:0][15:0]  t2_nxt, t2_r, tq_r;
  logic [1:0][19:0]  inner_nxt, inner2_r, inner3_r;
  logic [6:0][31:0]  hs, hx_nxt, hx_r, hp;
  logic [1:0][31:0]  t3p;
  logic [1:0][15:0]  t3_nxt, t3_r;
  logic [6:0][15:0]  hq_nxt, hq_r;
  logic [1:0][35:0]  sp;
  logic [1:0][16:0]  s_nxt, s_r;
  logic [1:0][15:0]  v_nxt, v_r;
  logic [16:0]       sy_r;
  hash3_t            hc5_r, hc6_r;
  logic [15:0]       n_nxt, n_r;

  always_comb begin
    x_clamp = pixel_x;
    y_clamp = pixel_y;
    if ({5'd0, pixel_x} >= 17'(MAX_WIDTH)) x_clamp = 12'(MAX_WIDTH - 1);
    if ({5'd0, pixel_y} >= 17'(MAX_HEIGHT)) y_clamp = 12'(MAX_HEIGHT - 1);
    pos_nxt[0] = {18'd0, x_clamp} * {12'd0, cfg.inv_grain_size};
    pos_nxt[1] = {18'd0, y_clamp} * {12'd0, cfg.inv_grain_size};
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      tsq[a] = {16'd0, pos_r[a][15:0]} * {16'd0, pos_r[a][15:0]};
      t2_nxt[a] = tsq[a][31:16];
      poly[a] = ({5'd0, tsq[a]} << 2) + ({5'd0, tsq[a]} << 1) + (37'd10 << 32)
              - ({21'd0, pos_r[a][15:0]} << 20) + ({21'd0, pos_r[a][15:0]} << 16);
      inner_nxt[a] = poly[a][35:16];
    end
    for (int d = 0; d < 2; d++) begin
      ax_nxt[d] = ({18'd0, pos_r[0][29:16]} + 32'(d)) * HASH_MUL_X;
      ay_nxt[d] = ({18'd0, pos_r[1][29:16]} + 32'(d)) * HASH_MUL_Y;
    end
    for (int s = 0; s < 3; s++) begin
      as_nxt[s] = ({16'd0, cfg.grain_seed} + 32'(s)) * HASH_MUL_S;
    end
    cx_nxt = {20'd0, pxy_r[0]} * HASH_MUL_X;
    cy_nxt = {20'd0, pxy_r[1]} * HASH_MUL_Y;
  end

  always_comb begin
    hs[0] = ax_r[0] + ay_r[0] + as_r[0];
    hs[1] = ax_r[1] + ay_r[0] + as_r[0];
    hs[2] = ax_r[0] + ay_r[1] + as_r[0];
    hs[3] = ax_r[1] + ay_r[1] + as_r[0];
    hs[4] = cx_r + cy_r + as_r[0];
    hs[5] = cx_r + cy_r + as_r[1];
    hs[6] = cx_r + cy_r + as_r[2];
    for (int k = 0; k < 7; k++) begin
      hx_nxt[k] = hs[k] ^ (hs[k] >> 13);
    end
    for (int a = 0; a < 2; a++) begin
      t3p[a] = {16'd0, t2_r[a]} * {16'd0, tq_r[a]};
      t3_nxt[a] = t3p[a][31:16];
    end
  end

  always_comb begin
    for (int k = 0; k < 7; k++) begin
      hp[k] = hx_r[k] * HASH_MUL_S;
      hq_nxt[k] = hp[k][31:16];
    end
    for (int a = 0; a < 2; a++) begin
      sp[a] = {20'd0, t3_r[a]} * {16'd0, inner3_r[a]};
      s_nxt[a] = (sp[a][35:16] > 20'd65536) ? ONE_Q16 : sp[a][32:16];
    end
  end

  assign v_nxt[0] = lerp_q16(hq_r[0], hq_r[1], s_r[0]);
  assign v_nxt[1] = lerp_q16(hq_r[2], hq_r[3], s_r[0]);
  assign n_nxt    = lerp_q16(v_r[0], v_r[1], sy_r);

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r    <= {pix_r[4:0], pix_in};
      pos_r    <= pos_nxt;
      pxy_r    <= {y_clamp, x_clamp};
      ax_r     <= ax_nxt;
      ay_r     <= ay_nxt;
      as_r     <= as_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      t2_r     <= t2_nxt;
      tq_r     <= {pos_r[1][15:0], pos_r[0][15:0]};
      inner2_r <= inner_nxt;
      hx_r     <= hx_nxt;
      t3_r     <= t3_nxt;
      inner3_r <= inner2_r;
      hq_r     <= hq_nxt;
      s_r      <= s_nxt;
      v_r      <= v_nxt;
      sy_r     <= s_r[1];
      hc5_r    <= {hq_r[6], hq_r[5], hq_r[4]};
      n_r      <= n_nxt;
      hc6_r    <= hc5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  assign item_out = '{valid: vld_r[5], noise: n_r, hc: hc6_r, pix: pix_r[5]};

endmodule

// File: design/fgpb_shape.sv
// Four-stage signed power shaping of centered noise by Mitchell log2 and exp2.
// Depends on fgpb_pkg.
module fgpb_shape (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  fgpb_pkg::noise_item_t item_in,
  input  fgpb_pkg::cfg_t        cfg,
  output fgpb_pkg::grain_item_t item_out
);
  import fgpb_pkg::*;

  logic [3:0]       vld_r;
  pix_t [3:0]       pix_r;
  hash3_t [3:0]     hc_r;
  logic [16:0]      mag_nxt, mag_r;
  logic [4:0]       e_nxt, e_r;
  logic [2:0]       pos_r;
  logic [1:0]       zero_r;
  logic [16:0]      mm, mm_sh;
  logic [4:0]       lead;
  logic [20:0]      nl_nxt, nl_r;
  logic [37:0]      np;
  logic [5:0]       ip_r;
  logic [15:0]      fp_r;
  logic [17:0]      sh;
  logic [16:0]      grain_nxt, grain_r;

  always_comb begin
    if (item_in.noise[15]) begin
      mag_nxt = {item_in.noise, 1'b0} - ONE_Q16;
    end else begin
      mag_nxt = ONE_Q16 - {item_in.noise, 1'b0};
    end
    e_nxt = '0;
    for (int i = 1; i < 17; i++) begin
      if (mag_nxt[i]) e_nxt = 5'(i);
    end
  end

  always_comb begin
    mm     = mag_r - (17'd1 << e_r);
    lead   = 5'd16 - e_r;
    mm_sh  = mm << lead;
    nl_nxt = {lead, 16'd0} - {5'd0, mm_sh[15:0]};
    np     = {17'd0, nl_r} * {21'd0, cfg.shaping_exponent};
  end

  always_comb begin
    sh = '0;
    if (!zero_r[1] && ip_r < 6'd17) begin
      sh = (18'd131072 - {2'd0, fp_r}) >> (ip_r[4:0] + 5'd1);
    end
    if (pos_r[2]) begin
      grain_nxt = HALF_Q16 + sh[17:1];
    end else begin
      grain_nxt = HALF_Q16 - sh[17:1];
    end
    if (grain_nxt > ONE_Q16) grain_nxt = ONE_Q16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r   <= {pix_r[2:0], item_in.pix};
      hc_r    <= {hc_r[2:0], item_in.hc};
      pos_r   <= {pos_r[1:0], item_in.noise[15]};
      mag_r   <= mag_nxt;
      e_r     <= e_nxt;
      zero_r  <= {zero_r[0], (mag_r == '0)};
      nl_r    <= nl_nxt;
      ip_r    <= np[37:32];
      fp_r    <= np[31:16];
      grain_r <= grain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], item_in.valid};
    end
  end

  assign item_out = '{valid: vld_r[3], grain: grain_r, hc: hc_r[3], pix: pix_r[3]};

endmodule

// File: design/fgpb_apply.sv
// Five-stage grain application: luma or color grain mix, intensity, channel
// scaling, blend with the original and saturation. Depends on fgpb_pkg.
module fgpb_apply (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  fgpb_pkg::grain_item_t item_in,
  input  fgpb_pkg::cfg_t        cfg,
  output logic                  out_valid,
  output fgpb_pkg::pix_t        out_pix
);
  import fgpb_pkg::*;

  logic [4:0]        vld_r;
  pix_t [3:0]        pix_r;
  pix_t              res_r;
  logic [2:0][15:0]  ch_in, ch3, ch4;
  logic [2:0][31:0]  mp;
  logic [31:0]       lp;
  logic [2:0][15:0]  m_nxt, m_r;
  logic [15:0]       luma_r;
  logic [16:0]       g1_r;
  logic [2:0][16:0]  gcm;
  logic [2:0][33:0]  pc;
  logic [2:0][16:0]  cm_nxt, cm_r;
  logic [2:0]        cn_r;
  logic [16:0]       k;
  logic [33:0]       ik_nxt, ik_r;
  logic              g_hi;
  logic [17:0]       glm;
  logic [16:0]       glm_r;
  logic              gln_r;
  logic [50:0]       plm;
  logic [2:0][16:0]  gvm_nxt, gvm_r;
  logic [2:0]        gvn_nxt, gvn_r;
  logic [2:0][17:0]  fct;
  logic [2:0]        fzero;
  logic [2:0][33:0]  npd;
  logic [2:0][16:0]  n_nxt, n_r;
  logic [2:0]        dn;
  logic [2:0][16:0]  dm;
  logic [2:0][33:0]  pr;
  logic [2:0][18:0]  sum;
  logic [2:0][15:0]  res_nxt;

  assign ch_in = {item_in.pix.blue, item_in.pix.green, item_in.pix.red};
  assign ch3   = {pix_r[2].blue, pix_r[2].green, pix_r[2].red};
  assign ch4   = {pix_r[3].blue, pix_r[3].green, pix_r[3].red};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mp[i] = {16'd0, item_in.hc[i]} * {17'd0, MIX_W_HASH}
            + {15'd0, item_in.grain} * {16'd0, MIX_W_GRAIN};
      m_nxt[i] = mp[i][31:16];
    end
    lp = {16'd0, ch_in[0]} * {18'd0, LUMA_W_R} + {16'd0, ch_in[1]} * {16'd0, LUMA_W_G}
       + {16'd0, ch_in[2]} * {19'd0, LUMA_W_B};
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (m_r[i][15]) gcm[i] = {m_r[i], 1'b0} - ONE_Q16;
      else            gcm[i] = ONE_Q16 - {m_r[i], 1'b0};
      pc[i] = {17'd0, gcm[i]} * {17'd0, cfg.grain_intensity};
      cm_nxt[i] = pc[i][32:16];
    end
    k      = ONE_Q16 - {2'd0, luma_r[15:1]};
    ik_nxt = {17'd0, k} * {17'd0, cfg.grain_intensity};
    g_hi   = g1_r[16] | g1_r[15];
    if (g_hi) glm = {g1_r, 1'b0} - 18'd65536;
    else      glm = 18'd65536 - {g1_r, 1'b0};
  end

  always_comb begin
    plm = {34'd0, glm_r} * {17'd0, ik_r};
    for (int i = 0; i < 3; i++) begin
      gvm_nxt[i] = cfg.color_mode ? cm_r[i] : plm[48:32];
      gvn_nxt[i] = cfg.color_mode ? cn_r[i] : gln_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fzero[i] = gvn_r[i] && (gvm_r[i] >= ONE_Q16);
      if (gvn_r[i]) fct[i] = {1'b0, ONE_Q16 - gvm_r[i]};
      else          fct[i] = {1'b0, ONE_Q16} + {1'b0, gvm_r[i]};
      npd[i] = {18'd0, ch3[i]} * {16'd0, fct[i]};
      if (fzero[i])                     n_nxt[i] = '0;
      else if (npd[i][33:16] > 18'd65536) n_nxt[i] = ONE_Q16;
      else                              n_nxt[i] = npd[i][32:16];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dn[i] = n_r[i] < {1'b0, ch4[i]};
      if (dn[i]) dm[i] = {1'b0, ch4[i]} - n_r[i];
      else       dm[i] = n_r[i] - {1'b0, ch4[i]};
      pr[i]  = {17'd0, dm[i]} * {17'd0, cfg.mix_amount};
      sum[i] = {3'd0, ch4[i]} + {1'b0, pr[i][33:16]};
      if (dn[i]) begin
        if (pr[i][33:16] > {2'd0, ch4[i]}) res_nxt[i] = '0;
        else                               res_nxt[i] = ch4[i] - pr[i][31:16];
      end else begin
        if (sum[i] > 19'd65535) res_nxt[i] = 16'hFFFF;
        else                    res_nxt[i] = sum[i][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r  <= {pix_r[2:0], item_in.pix};
      m_r    <= m_nxt;
      luma_r <= lp[31:16];
      g1_r   <= item_in.grain;
      cm_r   <= cm_nxt;
      cn_r   <= {~m_r[2][15], ~m_r[1][15], ~m_r[0][15]};
      ik_r   <= ik_nxt;
      glm_r  <= glm[16:0];
      gln_r  <= ~g_hi;
      gvm_r  <= gvm_nxt;
      gvn_r  <= gvn_nxt;
      n_r    <= n_nxt;
      res_r  <= '{alpha: pix_r[3].alpha, blue: res_nxt[2], green: res_nxt[1],
                  red: res_nxt[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], item_in.valid};
    end
  end

  assign out_valid = vld_r[4];
  assign out_pix   = res_r;

endmodule

// File: design/film_grain_pixel_blend.sv
// Top level of the film grain pixel blend: configuration registers, the noise,
// shaping and apply pipelines, and the output skid. Depends on fgpb_pkg, fgpb_if.
//
//   port      dir    handshake     payload
//   in_pix    sink   valid/ready   pixel_x, pixel_y, red/green/blue/alpha_in
//   out_pix   source valid/ready   red/green/blue/alpha_out
//   cfg_*     in     cfg_we        cfg_index, cfg_wdata
//
// One item per cycle while the skid is empty; 15 pipeline stages plus the output
// register form the path. A two-entry output (register plus skid) lets the pipeline
// run while a result waits; in_pix.ready drops only when the skid entry is full.
// Reset is synchronous; it clears valid bits and loads the configuration registers with their reset values.
module film_grain_pixel_blend #(
  parameter int MAX_WIDTH  = fgpb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fgpb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  fgpb_in_if.sink                          in_pix,
  fgpb_out_if.source                       out_pix,
  input  logic                             cfg_we,
  input  logic [fgpb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fgpb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import fgpb_pkg::*;

  cfg_t        cfg_r;
  logic        en;
  pix_t        pix_in;
  noise_item_t noise_item;
  grain_item_t grain_item;
  logic        pipe_valid;
  pix_t        pipe_pix;
  logic        out_valid_r, skid_valid_r;
  pix_t        out_data_r, skid_data_r;
  logic        out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{inv_grain_size: RST_INV_GRAIN_SIZE, shaping_exponent: RST_SHAPING_EXPONENT,
                 grain_seed: RST_GRAIN_SEED, color_mode: RST_COLOR_MODE,
                 grain_intensity: RST_GRAIN_INTENSITY, mix_amount: RST_MIX_AMOUNT};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INV_GRAIN_SIZE:   cfg_r.inv_grain_size   <= cfg_wdata;
        CFG_SHAPING_EXPONENT: cfg_r.shaping_exponent <= cfg_wdata[16:0];
        CFG_GRAIN_SEED:       cfg_r.grain_seed       <= cfg_wdata[15:0];
        CFG_COLOR_MODE:       cfg_r.color_mode       <= cfg_wdata[0];
        CFG_GRAIN_INTENSITY:  cfg_r.grain_intensity  <= cfg_wdata[16:0];
        CFG_MIX_AMOUNT:       cfg_r.mix_amount       <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  assign en           = !skid_valid_r;
  assign in_pix.ready = en;
  assign pix_in       = '{alpha: in_pix.alpha_in, blue: in_pix.blue_in,
                          green: in_pix.green_in, red: in_pix.red_in};

  fgpb_noise #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_noise (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_pix.valid),
    .pixel_x  (in_pix.pixel_x),
    .pixel_y  (in_pix.pixel_y),
    .pix_in   (pix_in),
    .cfg      (cfg_r),
    .item_out (noise_item)
  );

  fgpb_shape u_shape (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .item_in  (noise_item),
    .cfg      (cfg_r),
    .item_out (grain_item)
  );

  fgpb_apply u_apply (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .item_in   (grain_item),
    .cfg       (cfg_r),
    .out_valid (pipe_valid),
    .out_pix   (pipe_pix)
  );

  assign out_take = out_valid_r && out_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (pipe_valid) begin
      if (out_valid_r && !out_take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_r <= skid_data_r;
      end
    end else if (pipe_valid) begin
      if (out_valid_r && !out_take) begin
        skid_data_r <= pipe_pix;
      end else begin
        out_data_r <= pipe_pix;
      end
    end
  end

  assign out_pix.valid     = out_valid_r;
  assign out_pix.red_out   = out_data_r.red;
  assign out_pix.green_out = out_data_r.green;
  assign out_pix.blue_out  = out_data_r.blue;
  assign out_pix.alpha_out = out_data_r.alpha;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_pix.ready))
    else $error("skid filled without a stalled output");

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_pix.ready |=> skid_valid_r && $stable(skid_data_r))
    else $error("skid item lost or changed during a stall");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |=> $stable(noise_item) && $stable(grain_item))
    else $error("pipeline advanced while the skid was full");

endmodule
